FILE: sv/lfr_pkg.sv
package lfr_pkg;

   // Number of buffer frames that can be tracked.
   localparam int NUM_FRAMES = 16;

   // Frame numbers and slot indexes into the age chain.
   localparam int FRAME_W = 4;
   localparam int SLOT_W  = $clog2(NUM_FRAMES);

   // The tracked count runs from zero to the full frame count.
   localparam int COUNT_W = $clog2(NUM_FRAMES + 1);

   // Capacity register width and reset value.
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(NUM_FRAMES);

   // Request kinds; the unused code is a no-op.
   typedef enum logic [1:0] {
      REQ_VICTIM = 2'd0,
      REQ_PIN    = 2'd1,
      REQ_UNPIN  = 2'd2
   } req_kind_type;

   // Update order for the age chain in one cycle.
   typedef struct packed {
      logic [NUM_FRAMES-1:0] shift_mask;  // cells that take their younger neighbour
      logic                  write_en;    // append a frame at the youngest end
      logic [SLOT_W-1:0]     write_slot;
      logic [FRAME_W-1:0]    write_frame;
   } chain_op_type;

endpackage

FILE: sv/lfr_order_chain.sv
module lfr_order_chain
   import lfr_pkg::*;
(
   input  logic                  clock,
   input  chain_op_type          op,
   input  logic [FRAME_W-1:0]    lookup_frame,
   output logic [FRAME_W-1:0]    head_frame,
   output logic [NUM_FRAMES-1:0] match_mask
);

   // One cell per slot, oldest frame in slot zero. Cells above the tracked
   // count hold stale values and are masked by the controller.
   logic [FRAME_W-1:0] cell_ff [NUM_FRAMES];
   logic [FRAME_W-1:0] cell_in [NUM_FRAMES];

   // Each cell either compacts from its younger neighbour, takes the appended
   // frame, or holds.
   always_comb begin
      for (int k = 0; k < NUM_FRAMES; k++) begin
         cell_in[k] = cell_ff[k];
         if (op.shift_mask[k]) begin
            if (k + 1 < NUM_FRAMES) begin
               cell_in[k] = cell_ff[(k + 1) % NUM_FRAMES];
            end
         end else if (op.write_en && (op.write_slot == SLOT_W'(k))) begin
            cell_in[k] = op.write_frame;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_FRAMES; k++) begin
         cell_ff[k] <= cell_in[k];
      end
   end

   // Per-cell compare for the pin search.
   always_comb begin
      for (int k = 0; k < NUM_FRAMES; k++) begin
         match_mask[k] = (cell_ff[k] == lookup_frame);
      end
   end

   assign head_frame = cell_ff[0];

endmodule

FILE: sv/lru_frame_replacer.sv
// LRU frame replacer. Tracks evictable buffer frames in least-recently-unpinned
// order in a chain of sixteen cells that compacts on removal. One request beat
// is accepted per cycle when the result side is not stalled; each request gives
// exactly one result beat, registered first in the request register and then in
// the result register, and requests are processed strictly in
// order, each seeing the state left by the one before. A victim request returns
// and removes the oldest frame, a pin request removes the named frame, and an
// unpin request appends the frame unless it is already tracked or the count has
// reached the capacity register. Every result carries the tracked count after
// the request; victim_frame reads zero unless victim_valid is set. The capacity
// register resets to 16 and should be written only while no request is in
// flight. No clearing pass is needed after reset.
module lru_frame_replacer
   import lfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [FRAME_W-1:0] req_frame_id,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_victim_valid,
   output logic [FRAME_W-1:0] rsp_victim_frame,
   output logic [COUNT_W-1:0] rsp_tracked_count,
   // capacity register
   input  logic               csr_wr_en,
   input  logic [CAP_W-1:0]   csr_wr_data
);

   logic                  in_valid_ff, in_valid_in;
   logic [1:0]            in_type_ff;
   logic [FRAME_W-1:0]    in_frame_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_victim_valid_ff, out_victim_valid_in;
   logic [FRAME_W-1:0]    out_victim_frame_ff, out_victim_frame_in;
   logic [COUNT_W-1:0]    out_count_ff;
   logic [CAP_W-1:0]      cap_ff;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [NUM_FRAMES-1:0] mark_ff, mark_in;
   logic                  fire;
   logic                  req_take;
   logic                  frame_ok;
   logic                  frame_marked;
   logic [FRAME_W-1:0]    head_frame;
   logic [NUM_FRAMES-1:0] match_mask;
   logic [NUM_FRAMES-1:0] live_mask;
   logic [NUM_FRAMES-1:0] hit_mask;
   logic [NUM_FRAMES-1:0] pin_shift;
   chain_op_type          chain_op;

   // Handshake: the request register moves on whenever the result register
   // can take a beat.
   assign fire        = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !fire;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         mark_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         mark_ff  <= mark_in;
      end
   end

   // Request payload register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff  <= req_type;
         in_frame_ff <= req_frame_id;
      end
   end

   lfr_order_chain u_chain (
      .clock        (clock),
      .op           (chain_op),
      .lookup_frame (in_frame_ff),
      .head_frame   (head_frame),
      .match_mask   (match_mask)
   );

   // Slots below the count hold tracked frames.
   always_comb begin
      for (int k = 0; k < NUM_FRAMES; k++) begin
         live_mask[k] = (COUNT_W'(k) < count_ff);
      end
   end

   // A pin compacts every slot from the matching one upwards.
   assign hit_mask = match_mask & live_mask;
   always_comb begin
      for (int k = 0; k < NUM_FRAMES; k++) begin
         pin_shift[k] = |(hit_mask << (NUM_FRAMES - 1 - k));
      end
   end

   assign frame_ok     = ({1'b0, in_frame_ff} < (FRAME_W + 1)'(NUM_FRAMES));
   assign frame_marked = mark_ff[in_frame_ff[SLOT_W-1:0]];

   // Request decode and state update.
   always_comb begin
      count_in             = count_ff;
      mark_in              = mark_ff;
      chain_op.shift_mask  = '0;
      chain_op.write_en    = 1'b0;
      chain_op.write_slot  = count_ff[SLOT_W-1:0];
      chain_op.write_frame = in_frame_ff;
      out_victim_valid_in  = 1'b0;
      out_victim_frame_in  = '0;
      if (fire) begin
         unique case (in_type_ff)
            REQ_VICTIM: begin
               if (count_ff != '0) begin
                  chain_op.shift_mask = '1;
                  mark_in[head_frame[SLOT_W-1:0]] = 1'b0;
                  count_in = count_ff - COUNT_W'(1);
                  out_victim_valid_in = 1'b1;
                  out_victim_frame_in = head_frame;
               end
            end
            REQ_PIN: begin
               if (frame_ok && frame_marked) begin
                  chain_op.shift_mask = pin_shift;
                  mark_in[in_frame_ff[SLOT_W-1:0]] = 1'b0;
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            REQ_UNPIN: begin
               if (frame_ok && !frame_marked && (count_ff < cap_ff)
                   && (count_ff < COUNT_W'(NUM_FRAMES))) begin
                  chain_op.write_en = 1'b1;
                  mark_in[in_frame_ff[SLOT_W-1:0]] = 1'b1;
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            default: begin
               // Unknown request: nothing changes.
            end
         endcase
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (fire) begin
         out_victim_valid_ff <= out_victim_valid_in;
         out_victim_frame_ff <= out_victim_frame_in;
         out_count_ff        <= count_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_victim_valid  = out_victim_valid_ff;
   assign rsp_victim_frame  = out_victim_frame_ff;
   assign rsp_tracked_count = out_count_ff;

endmodule

FILE: sv/lfr_checker.sv
module lfr_checker
   import lfr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_type,
   input logic [FRAME_W-1:0] req_frame_id,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_victim_valid,
   input logic [FRAME_W-1:0] rsp_victim_frame,
   input logic [COUNT_W-1:0] rsp_tracked_count,
   input logic               csr_wr_en,
   input logic [CAP_W-1:0]   csr_wr_data
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_victim_valid)
         && $stable(rsp_victim_frame) && $stable(rsp_tracked_count))
      else $error("result beat changed while stalled");

   // The tracked count never exceeds the number of frames.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tracked_count <= COUNT_W'(NUM_FRAMES))
      else $error("tracked count beyond frame count");

   // After an eviction at least one slot is free.
   a_victim_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_victim_valid |-> rsp_tracked_count < COUNT_W'(NUM_FRAMES))
      else $error("eviction left a full table");

   // The frame field reads zero when no frame was evicted.
   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_victim_valid |-> rsp_victim_frame == '0)
      else $error("victim frame set without an eviction");

endmodule

bind lru_frame_replacer lfr_checker u_lfr_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import lfr_pkg::*;

   // The fourth request code is not defined by the block and must change nothing.
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   // The run is cut off here if the block stops answering.
   localparam int CYCLE_LIMIT = 400_000;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_BEATS = 165;

   // One result beat as the block presents it.
   typedef struct packed {
      logic               victim_valid;
      logic [FRAME_W-1:0] victim_frame;
      logic [COUNT_W-1:0] tracked_count;
   } outcome_type;

   // One row of the directed sequence; the hand-written outcome is used when fixed is set.
   typedef struct {
      logic [1:0]         kind;
      logic [FRAME_W-1:0] frame;
      bit                 fixed;
      outcome_type        outcome;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = REQ_VICTIM;
   logic [FRAME_W-1:0] req_frame_id = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_victim_valid;
   logic [FRAME_W-1:0] rsp_victim_frame;
   logic [COUNT_W-1:0] rsp_tracked_count;
   logic               csr_wr_en = 1'b0;
   logic [CAP_W-1:0]   csr_wr_data = '0;

   // Shadow of the replacer: tracked frames oldest first, membership and capacity.
   logic [FRAME_W-1:0] evict_order[$];
   logic               frame_held[NUM_FRAMES];
   logic [CAP_W-1:0]   capacity_shadow = CAP_RESET;

   outcome_type pending_outcomes[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int          stall_left = 0;

   directed_row_type directed_rows[16] = '{
      '{REQ_VICTIM,  4'd0,  1'b1, '{1'b0, 4'd0,  5'd0}},
      '{REQ_PIN,     4'd5,  1'b1, '{1'b0, 4'd0,  5'd0}},
      '{REQ_UNKNOWN, 4'd15, 1'b1, '{1'b0, 4'd0,  5'd0}},
      '{REQ_UNPIN,   4'd0,  1'b1, '{1'b0, 4'd0,  5'd1}},
      '{REQ_UNPIN,   4'd15, 1'b1, '{1'b0, 4'd0,  5'd2}},
      '{REQ_UNPIN,   4'd0,  1'b1, '{1'b0, 4'd0,  5'd2}},
      '{REQ_UNPIN,   4'd7,  1'b0, '{1'b0, 4'd0,  5'd0}},
      '{REQ_UNPIN,   4'd10, 1'b0, '{1'b0, 4'd0,  5'd0}},
      '{REQ_PIN,     4'd15, 1'b0, '{1'b0, 4'd0,  5'd0}},
      '{REQ_VICTIM,  4'd0,  1'b1, '{1'b1, 4'd0,  5'd2}},
      '{REQ_PIN,     4'd7,  1'b0, '{1'b0, 4'd0,  5'd0}},
      '{REQ_UNPIN,   4'd15, 1'b0, '{1'b0, 4'd0,  5'd0}},
      '{REQ_UNKNOWN, 4'd0,  1'b0, '{1'b0, 4'd0,  5'd0}},
      '{REQ_VICTIM,  4'd15, 1'b0, '{1'b0, 4'd0,  5'd0}},
      '{REQ_VICTIM,  4'd0,  1'b0, '{1'b0, 4'd0,  5'd0}},
      '{REQ_VICTIM,  4'd0,  1'b1, '{1'b0, 4'd0,  5'd0}}
   };

   // Capacity and share of unpin requests for each random phase.
   int phase_capacity[NUM_PHASES] = '{31, 0, 1, 16, -1, 31, 2, -1, 16, 12};
   int phase_unpin[NUM_PHASES]    = '{75, 40, 45, 70, 50, 30, 55, 50, 60, 45};

   lru_frame_replacer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_frame_id      (req_frame_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_victim_valid  (rsp_victim_valid),
      .rsp_victim_frame  (rsp_victim_frame),
      .rsp_tracked_count (rsp_tracked_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Works out the outcome of one request and updates the shadow state.
   function automatic outcome_type track_request(input logic [1:0] kind,
                                                 input logic [FRAME_W-1:0] fid);
      outcome_type        res;
      logic [FRAME_W-1:0] oldest;
      res = '0;
      case (kind)
         REQ_VICTIM: begin
            if (evict_order.size() != 0) begin
               oldest = evict_order[0];
               evict_order.delete(0);
               frame_held[oldest] = 1'b0;
               res.victim_valid = 1'b1;
               res.victim_frame = oldest;
            end
         end
         REQ_PIN: begin
            if (frame_held[fid]) begin
               for (int k = 0; k < evict_order.size(); k++) begin
                  if (evict_order[k] == fid) begin
                     evict_order.delete(k);
                     break;
                  end
               end
               frame_held[fid] = 1'b0;
            end
         end
         REQ_UNPIN: begin
            // Already tracked frames keep their age; a full table or capacity drops it.
            if (!frame_held[fid] && evict_order.size() < int'(capacity_shadow) &&
                evict_order.size() < NUM_FRAMES) begin
               evict_order.insert(evict_order.size(), fid);
               frame_held[fid] = 1'b1;
            end
         end
         default: ;
      endcase
      res.tracked_count = COUNT_W'(evict_order.size());
      return res;
   endfunction

   task automatic flag_mismatch(input string field, input int got, input int want);
      mismatch_count++;
      $display("cycle %0d: %s mismatch, got %0d, expected %0d",
               cycle_count, field, got, want);
   endtask

   // Presents one request beat and holds it until the block takes it.
   task automatic send_beat(input logic [1:0] kind, input logic [FRAME_W-1:0] fid,
                            input bit fixed, input outcome_type hand_value);
      outcome_type predicted;
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_frame_id <= fid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = track_request(kind, fid);
      pending_outcomes.insert(pending_outcomes.size(), fixed ? hand_value : predicted);
   endtask

   // A random gap in the request stream, taken between beats.
   task automatic maybe_gap();
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every outstanding result has come back.
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity_shadow = value;
   endtask

   // Result side back-pressure comes in bursts whose length is drawn at random.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Each accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = pending_outcomes[0];
            pending_outcomes.delete(0);
            if (rsp_victim_valid !== want.victim_valid)
               flag_mismatch("victim_valid", int'(rsp_victim_valid),
                             int'(want.victim_valid));
            if (rsp_victim_frame !== want.victim_frame)
               flag_mismatch("victim_frame", int'(rsp_victim_frame),
                             int'(want.victim_frame));
            if (rsp_tracked_count !== want.tracked_count)
               flag_mismatch("tracked_count", int'(rsp_tracked_count),
                             int'(want.tracked_count));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lru_frame_replacer verification failed");
         $finish;
      end
   end

   initial begin
      logic [1:0]         kind;
      logic [FRAME_W-1:0] fid;
      int                 roll;
      int                 cap;

      foreach (frame_held[f]) frame_held[f] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset capacity.
      gap_pct   = 10;
      stall_pct = 10;
      foreach (directed_rows[r]) begin
         maybe_gap();
         send_beat(directed_rows[r].kind, directed_rows[r].frame,
                   directed_rows[r].fixed, directed_rows[r].outcome);
      end

      // Random phases, each at its own capacity; the last one runs without idling.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_requests();
         cap = (phase_capacity[p] < 0) ? $urandom_range(0, 31) : phase_capacity[p];
         write_capacity(CAP_W'(cap));
         if (p == NUM_PHASES - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = $urandom_range(0, 3) * 7;
            stall_pct = $urandom_range(0, 3) * 7;
         end
         for (int n = 0; n < PHASE_BEATS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < phase_unpin[p]) begin
               kind = REQ_UNPIN;
            end else begin
               roll = $urandom_range(0, 19);
               kind = (roll < 9) ? REQ_VICTIM : (roll < 18) ? REQ_PIN : REQ_UNKNOWN;
            end
            fid = FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
            // Pins mostly name a tracked frame; some unpins repeat one.
            if (evict_order.size() != 0 &&
                ((kind == REQ_PIN && $urandom_range(0, 9) < 6) ||
                 (kind == REQ_UNPIN && $urandom_range(0, 9) < 2)))
               fid = evict_order[$urandom_range(0, evict_order.size() - 1)];
            maybe_gap();
            send_beat(kind, fid, 1'b0, '0);
         end
      end

      drain_requests();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("lru_frame_replacer verification clean");
      else
         $display("lru_frame_replacer verification failed");
      $finish;
   end

endmodule
